@@ src/tbc_pkg.sv @@
`timescale 1ns / 1ps
package tbc_pkg;

    localparam int MEM_BYTES_DEF = 256;
    localparam int REG_COUNT     = 16;

    // command modes
    localparam logic [2:0] MODE_WR_MEM = 3'd0;
    localparam logic [2:0] MODE_SET_PC = 3'd1;
    localparam logic [2:0] MODE_EXEC   = 3'd2;
    localparam logic [2:0] MODE_RD_MEM = 3'd3;
    localparam logic [2:0] MODE_RD_REG = 3'd4;

    // opcodes
    localparam logic [3:0] OP_LOAD  = 4'h1;
    localparam logic [3:0] OP_LDI   = 4'h2;
    localparam logic [3:0] OP_STORE = 4'h3;
    localparam logic [3:0] OP_MOVE  = 4'h4;
    localparam logic [3:0] OP_ADD   = 4'h5;
    localparam logic [3:0] OP_FADD  = 4'h6;
    localparam logic [3:0] OP_JMP   = 4'hB;
    localparam logic [3:0] OP_HALT  = 4'hC;

    typedef enum logic [1:0] {
        MS_ADDR,
        MS_PC,
        MS_PC1,
        MS_XY
    } t_mem_src;

    typedef enum logic [1:0] {
        RS_ADDR,
        RS_X1,
        RS_X2
    } t_rf_src;

    typedef struct packed {
        logic     ld_item;
        t_mem_src mem_src;
        t_rf_src  rf_src;
        logic     cap_hi;
        logic     cap_lo;
        logic     cap_a;
        logic     cap_b;
        logic     fadd;
        logic     commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic exec_go;
    } t_ctl_sts;

endpackage

@@ src/tbc_ctrl.sv @@
`timescale 1ns / 1ps
module tbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_stall,
    input  tbc_pkg::t_ctl_sts i_sts,
    output tbc_pkg::t_ctl_cmd o_cmd,
    output logic              o_stall,
    output logic              o_valid
);
    import tbc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_FHI, S_FLO, S_DEC, S_RDA, S_RDB, S_RDW, S_FADD, S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;
    logic   accept;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_vld;
    assign accept  = i_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd         = '0;
        o_cmd.mem_src = MS_ADDR;
        o_cmd.rf_src  = RS_ADDR;
        n_state       = r_state;
        case (r_state)
            S_IDLE: begin
                o_cmd.ld_item = accept;
                if (accept) n_state = S_DISP;
            end
            S_DISP: n_state = i_sts.exec_go ? S_FHI : S_EXEC;
            S_FHI: begin
                o_cmd.mem_src = MS_PC;
                n_state       = S_FLO;
            end
            S_FLO: begin
                o_cmd.mem_src = MS_PC1;
                o_cmd.cap_hi  = 1'b1;
                n_state       = S_DEC;
            end
            S_DEC: begin
                o_cmd.cap_lo = 1'b1;
                n_state      = S_RDA;
            end
            S_RDA: begin
                o_cmd.mem_src = MS_XY;
                o_cmd.rf_src  = RS_X1;
                n_state       = S_RDB;
            end
            S_RDB: begin
                o_cmd.rf_src = RS_X2;
                o_cmd.cap_a  = 1'b1;
                n_state      = S_RDW;
            end
            S_RDW: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_FADD;
            end
            S_FADD: begin
                o_cmd.fadd = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.commit = !(r_out_vld && i_stall);
                if (o_cmd.commit) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        n_out_vld = o_cmd.commit ? 1'b1 : (r_out_vld && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

@@ src/tbc_dp.sv @@
`timescale 1ns / 1ps
module tbc_dp #(
    parameter int MEM_BYTES = tbc_pkg::MEM_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tbc_pkg::t_ctl_cmd i_cmd,
    output tbc_pkg::t_ctl_sts o_sts,
    input  logic [2:0]        i_mode,
    input  logic [7:0]        i_address,
    input  logic [7:0]        i_data,
    output logic [7:0]        o_pc_after,
    output logic [15:0]       o_instruction_word,
    output logic              o_halted,
    output logic [7:0]        o_read_value,
    output logic              o_reg_write_valid,
    output logic [3:0]        o_reg_write_index,
    output logic [7:0]        o_reg_write_value,
    output logic              o_mem_write_valid,
    output logic [7:0]        o_mem_write_address,
    output logic [7:0]        o_mem_write_value,
    output logic              o_jump_taken
);
    import tbc_pkg::*;

    localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

    typedef logic [AW-1:0] t_mod_tbl [256];

    function automatic t_mod_tbl build_mod_tbl();
        t_mod_tbl t;
        for (int i = 0; i < 256; i++) t[i] = AW'(i % MEM_BYTES);
        return t;
    endfunction

    localparam t_mod_tbl MOD_TBL = build_mod_tbl();

    function automatic logic signed [12:0] fdec(input logic [7:0] b);
        logic signed [12:0] mag;
        mag = 13'(12'(b[3:0]) << b[6:4]);
        return b[7] ? -mag : mag;
    endfunction

    // item and machine state
    logic [2:0]  r_mode;
    logic [7:0]  r_addr, r_data;
    logic [7:0]  r_pc;
    logic        r_halt;
    logic [15:0] r_ir;
    logic [7:0]  r_regs [REG_COUNT];
    logic [7:0]  r_mem [MEM_BYTES];
    logic [MEM_BYTES-1:0] r_mem_vld;

    logic [7:0]  r_mem_q, r_rf_q, r_memop, r_opa, r_opb;
    logic        r_mem_vq;
    logic signed [12:0] r_fsum;

    logic [3:0]  op, ra, rb, rc, x1, x2, rf_idx;
    logic [7:0]  xy, mem_rd_byte;
    logic [AW-1:0] mem_rd_a;

    assign op = r_ir[15:12];
    assign ra = r_ir[11:8];
    assign rb = r_ir[7:4];
    assign rc = r_ir[3:0];
    assign xy = r_ir[7:0];
    assign mem_rd_byte = r_mem_vq ? r_mem_q : 8'h00;
    assign o_sts.exec_go = (r_mode == MODE_EXEC) && !r_halt;

    always_comb begin
        case (op)
            OP_MOVE, OP_ADD, OP_FADD: x1 = rb;
            default:                  x1 = ra;
        endcase
        x2 = (op == OP_JMP) ? 4'd0 : rc;
        case (i_cmd.rf_src)
            RS_X1:   rf_idx = x1;
            RS_X2:   rf_idx = x2;
            default: rf_idx = r_addr[3:0];
        endcase
        case (i_cmd.mem_src)
            MS_PC:   mem_rd_a = MOD_TBL[r_pc];
            MS_PC1:  mem_rd_a = MOD_TBL[8'(r_pc + 8'd1)];
            MS_XY:   mem_rd_a = MOD_TBL[xy];
            default: mem_rd_a = MOD_TBL[r_addr];
        endcase
    end

    // float encode of the registered sum
    logic [12:0] fs_abs;
    logic [11:0] fmag;
    logic [3:0]  fp;
    logic [2:0]  fe;
    logic [7:0]  fres;

    always_comb begin
        fs_abs = r_fsum[12] ? 13'(-r_fsum) : 13'(r_fsum);
        fmag   = fs_abs[11:0];
        fp     = 4'd0;
        for (int i = 0; i < 12; i++) if (fmag[i]) fp = 4'(i);
        fe     = 3'(fp - 4'd3);
        if (fmag == 12'd0)     fres = 8'h00;
        else if (fmag < 12'd16) fres = {r_fsum[12], 3'd0, fmag[3:0]};
        else if (fp > 4'd10)   fres = {r_fsum[12], 7'h7F};
        else                   fres = {r_fsum[12], fe, 4'(fmag >> fe)};
    end

    // commit values
    logic [7:0]  n_pc;
    logic        n_halt;
    logic [15:0] n_iw;
    logic [7:0]  n_rv;
    logic        n_rwv, n_mwv, n_jmp;
    logic [3:0]  n_rwi;
    logic [7:0]  n_rwd, n_mwa, n_mwd;

    always_comb begin
        n_pc  = r_pc;
        n_halt = r_halt;
        n_iw  = 16'h0;
        n_rv  = 8'h00;
        n_rwv = 1'b0;
        n_rwi = 4'd0;
        n_rwd = 8'h00;
        n_mwv = 1'b0;
        n_mwa = 8'h00;
        n_mwd = 8'h00;
        n_jmp = 1'b0;
        case (r_mode)
            MODE_SET_PC: begin
                n_pc   = r_addr;
                n_halt = 1'b0;
            end
            MODE_EXEC: if (!r_halt) begin
                n_iw = r_ir;
                n_pc = 8'(r_pc + 8'd2);
                case (op)
                    OP_LOAD: begin
                        n_rwv = 1'b1; n_rwi = ra; n_rwd = r_memop;
                    end
                    OP_LDI: begin
                        n_rwv = 1'b1; n_rwi = ra; n_rwd = xy;
                    end
                    OP_STORE: begin
                        n_mwv = 1'b1; n_mwa = xy; n_mwd = r_opa;
                    end
                    OP_MOVE: begin
                        n_rwv = 1'b1; n_rwi = rc; n_rwd = (rb == rc) ? 8'h00 : r_opa;
                    end
                    OP_ADD: begin
                        n_rwv = 1'b1; n_rwi = ra; n_rwd = 8'(r_opa + r_opb);
                    end
                    OP_FADD: begin
                        n_rwv = 1'b1; n_rwi = ra; n_rwd = fres;
                    end
                    OP_JMP: if (r_opa == r_opb) begin
                        n_jmp = 1'b1; n_pc = xy;
                    end
                    OP_HALT: n_halt = 1'b1;
                    default: ;
                endcase
            end
            MODE_RD_MEM: n_rv = mem_rd_byte;
            MODE_RD_REG: n_rv = r_rf_q;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= 8'h00;
            r_halt    <= 1'b0;
            r_ir      <= 16'h0;
            r_mem_vld <= '0;
            for (int i = 0; i < REG_COUNT; i++) r_regs[i] <= 8'h00;
        end else begin
            if (i_cmd.cap_hi) r_ir[15:8] <= mem_rd_byte;
            if (i_cmd.cap_lo) r_ir[7:0]  <= mem_rd_byte;
            if (i_cmd.fadd && op == OP_MOVE) r_regs[rb] <= 8'h00;
            if (i_cmd.commit) begin
                r_pc   <= n_pc;
                r_halt <= n_halt;
                if (n_rwv) r_regs[n_rwi] <= n_rwd;
                if (r_mode == MODE_WR_MEM) r_mem_vld[MOD_TBL[r_addr]] <= 1'b1;
                if (n_mwv) r_mem_vld[MOD_TBL[n_mwa]] <= 1'b1;
            end
        end
    end

    // memory and datapath registers
    always_ff @(posedge i_clk) begin
        r_mem_q  <= r_mem[mem_rd_a];
        r_mem_vq <= r_mem_vld[mem_rd_a];
        r_rf_q   <= r_regs[rf_idx];
        if (i_cmd.commit && r_mode == MODE_WR_MEM) r_mem[MOD_TBL[r_addr]] <= r_data;
        if (i_cmd.commit && n_mwv) r_mem[MOD_TBL[n_mwa]] <= n_mwd;
        if (i_cmd.ld_item) begin
            r_mode <= i_mode;
            r_addr <= i_address;
            r_data <= i_data;
        end
        if (i_cmd.cap_a) begin
            r_opa   <= r_rf_q;
            r_memop <= mem_rd_byte;
        end
        if (i_cmd.cap_b) r_opb <= r_rf_q;
        if (i_cmd.fadd) r_fsum <= 13'(fdec(r_opa) + fdec(r_opb));
        if (i_cmd.commit) begin
            o_pc_after          <= n_pc;
            o_instruction_word  <= n_iw;
            o_halted            <= n_halt;
            o_read_value        <= n_rv;
            o_reg_write_valid   <= n_rwv;
            o_reg_write_index   <= n_rwi;
            o_reg_write_value   <= n_rwd;
            o_mem_write_valid   <= n_mwv;
            o_mem_write_address <= n_mwa;
            o_mem_write_value   <= n_mwd;
            o_jump_taken        <= n_jmp;
        end
    end

endmodule

@@ src/textbook_byte_cpu_step_top.sv @@
`timescale 1ns / 1ps
// byte cpu step engine: one beat in runs one command (write memory, set pc,
// execute one instruction, read memory or read a register) and gives one
// result beat. a non-execute command, or an execute while halted, holds the
// input side through the dispatch and commit states; a running execute
// holds it also through fetch, operand reads and the float sum. results
// show from a register loaded at commit. the execute length is set by the
// single registered read port of the byte memory (two fetch reads and an
// operand read), the single register file read port and the float sum state.
// memory and registers read as zero after reset: the memory has one valid
// bit per byte, so no clearing pass is needed.
// a new command is taken while the previous result still waits; its commit
// then waits until the result side takes the older beat.
module textbook_byte_cpu_step_top #(
    parameter int MEM_BYTES = tbc_pkg::MEM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_mode,
    input  logic [7:0]  i_address,
    input  logic [7:0]  i_data,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_pc_after,
    output logic [15:0] o_instruction_word,
    output logic        o_halted,
    output logic [7:0]  o_read_value,
    output logic        o_reg_write_valid,
    output logic [3:0]  o_reg_write_index,
    output logic [7:0]  o_reg_write_value,
    output logic        o_mem_write_valid,
    output logic [7:0]  o_mem_write_address,
    output logic [7:0]  o_mem_write_value,
    output logic        o_jump_taken
);
    import tbc_pkg::*;

    // controller to datapath commands and status
    t_ctl_cmd cmd;
    t_ctl_sts sts;

    // sequencer: fetch, operand reads, float sum, commit
    tbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    // registers, memory, alu and result register
    tbc_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_mode              (i_mode),
        .i_address           (i_address),
        .i_data              (i_data),
        .o_pc_after          (o_pc_after),
        .o_instruction_word  (o_instruction_word),
        .o_halted            (o_halted),
        .o_read_value        (o_read_value),
        .o_reg_write_valid   (o_reg_write_valid),
        .o_reg_write_index   (o_reg_write_index),
        .o_reg_write_value   (o_reg_write_value),
        .o_mem_write_valid   (o_mem_write_valid),
        .o_mem_write_address (o_mem_write_address),
        .o_mem_write_value   (o_mem_write_value),
        .o_jump_taken        (o_jump_taken)
    );

endmodule

@@ src/tbc_checker.sv @@
`timescale 1ns / 1ps
module tbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_instruction_word,
    input logic [7:0]  o_read_value,
    input logic        o_reg_write_valid,
    input logic        o_mem_write_valid,
    input logic        o_jump_taken
);
    import tbc_pkg::*;

    // a beat taken keeps the block busy in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall) else $error("no busy after accept");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reg_write_valid |-> !o_mem_write_valid && o_read_value == 8'h00)
        else $error("reg write with other effects");

    a_jmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_jump_taken |-> o_instruction_word[15:12] == OP_JMP)
        else $error("jump without jump opcode");

    a_st: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mem_write_valid |-> o_instruction_word[15:12] == OP_STORE)
        else $error("store without store opcode");

endmodule

bind textbook_byte_cpu_step_top tbc_checker u_tbc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_stall            (o_stall),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_instruction_word (o_instruction_word),
    .o_read_value       (o_read_value),
    .o_reg_write_valid  (o_reg_write_valid),
    .o_mem_write_valid  (o_mem_write_valid),
    .o_jump_taken       (o_jump_taken)
);
